FILE: rtl/tpst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpst_pkg;

    localparam int SLOTS_DEFAULT = 32;
    localparam int PORTS_DEFAULT = 16;
    localparam int MAX_RESULTS   = 32;

    localparam logic [11:0] ON_LEVEL_RESET = 12'd4000;

    // register index, taken from paddr[2]
    localparam logic REG_ON_LEVEL = 1'b0;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_ON   = 2'd0,
        ST_OFF  = 2'd1,
        ST_DROP = 2'd2
    } status_t;

    // command word from front to back: stamp is the expiry for a start,
    // the current time for a tick
    typedef struct packed
    {
        op_t         op;
        logic [3:0]  port;
        logic [31:0] stamp;
    } cmd_t;

    typedef struct packed
    {
        logic [3:0]  port;
        logic [11:0] level;
        status_t     status;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/tpst_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module tpst_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tpst_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tpst_front #(
    parameter int PORTS = tpst_pkg::PORTS_DEFAULT
) (
    input  wire logic        push,
    output logic             full,
    input  wire logic        operation,
    input  wire logic [3:0]  port,
    input  wire logic [15:0] duration_ms,
    input  wire logic [31:0] now_ms,
    input  wire logic        cmd_full,
    output logic             cmd_push,
    output tpst_pkg::cmd_t   cmd_data
);

    // port modulo PORTS by repeated subtraction on a 4-bit value
    function automatic logic [3:0] port_wrap(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        for (int k = 0; k < 8; k++)
        begin
            if ({1'b0, r} >= 5'(PORTS))
            begin
                r = r - 4'(PORTS);
            end
        end
        return r;
    endfunction

    tpst_pkg::op_t op;

    assign op       = tpst_pkg::op_t'(operation);
    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full;

    always_comb
    begin
        cmd_data.op   = op;
        cmd_data.port = port_wrap(port);
        if (op == tpst_pkg::OP_START)
        begin
            cmd_data.stamp = now_ms + {16'd0, duration_ms};
        end
        else
        begin
            cmd_data.stamp = now_ms;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tpst_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module tpst_engine #(
    parameter int SLOTS = tpst_pkg::SLOTS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_empty,
    input  wire tpst_pkg::cmd_t cmd_data,
    output logic                cmd_pop,
    input  wire logic [11:0]    on_level,
    input  wire logic           res_full,
    output logic                res_push,
    output tpst_pkg::res_t      res_data
);

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int N_W   = $clog2(tpst_pkg::MAX_RESULTS + 1);

    typedef enum logic [1:0]
    {
        IDLE,
        FIND,
        SCAN,
        CMP
    } state_t;

    state_t          state_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [N_W-1:0]   cnt_reg;
    tpst_pkg::cmd_t   cmd_reg;
    logic [SLOTS-1:0] used_reg;
    logic             pend_valid_reg;
    logic [3:0]       pend_port_reg;
    logic             res_valid_reg;
    tpst_pkg::res_t   res_reg;

    logic [3:0]       port_mem [SLOTS];
    logic [31:0]      exp_mem  [SLOTS];
    logic [3:0]       port_rd_reg;
    logic [31:0]      exp_rd_reg;

    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] idx_next;
    logic             can_emit;
    logic             mem_we;
    logic             expired;
    logic             res_load;

    assign idx      = idx_reg[IDX_W-1:0];
    assign idx_next = idx_reg + 1'b1;
    assign can_emit = !res_valid_reg || !res_full;
    assign cmd_pop  = (state_reg == IDLE) && !cmd_empty;
    assign res_push = res_valid_reg;
    assign res_data = res_reg;
    assign mem_we   = (state_reg == FIND) && !used_reg[idx] && can_emit;
    assign expired  = (exp_rd_reg <= cmd_reg.stamp);

    // a new word goes into the output register this cycle
    always_comb
    begin
        case (state_reg)
            FIND:
            begin
                res_load = can_emit && (!used_reg[idx] || (idx_reg == CNT_W'(SLOTS - 1)));
            end
            SCAN:
            begin
                res_load = (idx_reg == CNT_W'(SLOTS)) && pend_valid_reg && can_emit;
            end
            CMP:
            begin
                res_load = expired && pend_valid_reg && can_emit;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // slot storage, read address follows the scan index
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            port_mem[idx] <= cmd_reg.port;
            exp_mem[idx]  <= cmd_reg.stamp;
        end
        port_rd_reg <= port_mem[idx];
        exp_rd_reg  <= exp_mem[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_full)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        cmd_reg <= cmd_data;
                        idx_reg <= '0;
                        cnt_reg <= '0;
                        if (cmd_data.op == tpst_pkg::OP_START)
                        begin
                            state_reg <= FIND;
                        end
                        else
                        begin
                            state_reg <= SCAN;
                        end
                    end
                end

                FIND:
                begin
                    if (!used_reg[idx])
                    begin
                        if (can_emit)
                        begin
                            used_reg[idx]  <= 1'b1;
                            res_reg.port   <= cmd_reg.port;
                            res_reg.level  <= on_level;
                            res_reg.status <= tpst_pkg::ST_ON;
                            res_reg.last   <= 1'b1;
                            state_reg      <= IDLE;
                        end
                    end
                    else if (idx_reg == CNT_W'(SLOTS - 1))
                    begin
                        // table full
                        if (can_emit)
                        begin
                            res_reg.port   <= cmd_reg.port;
                            res_reg.level  <= '0;
                            res_reg.status <= tpst_pkg::ST_DROP;
                            res_reg.last   <= 1'b1;
                            state_reg      <= IDLE;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_next;
                    end
                end

                SCAN:
                begin
                    if (idx_reg == CNT_W'(SLOTS))
                    begin
                        if (!pend_valid_reg)
                        begin
                            state_reg <= IDLE;
                        end
                        else if (can_emit)
                        begin
                            res_reg.port   <= pend_port_reg;
                            res_reg.level  <= '0;
                            res_reg.status <= tpst_pkg::ST_OFF;
                            res_reg.last   <= 1'b1;
                            pend_valid_reg <= 1'b0;
                            state_reg      <= IDLE;
                        end
                    end
                    else if (used_reg[idx] && (cnt_reg < N_W'(tpst_pkg::MAX_RESULTS)))
                    begin
                        state_reg <= CMP;
                    end
                    else
                    begin
                        idx_reg <= idx_next;
                    end
                end

                CMP:
                begin
                    if (!expired)
                    begin
                        idx_reg   <= idx_next;
                        state_reg <= SCAN;
                    end
                    else if (!pend_valid_reg || can_emit)
                    begin
                        // the held turn-off is not the final one, a later slot expired
                        if (pend_valid_reg)
                        begin
                            res_reg.port   <= pend_port_reg;
                            res_reg.level  <= '0;
                            res_reg.status <= tpst_pkg::ST_OFF;
                            res_reg.last   <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_port_reg  <= port_rd_reg;
                        used_reg[idx]  <= 1'b0;
                        cnt_reg        <= cnt_reg + 1'b1;
                        idx_reg        <= idx_next;
                        state_reg      <= SCAN;
                    end
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/timed_pulse_slot_table.sv
// a start searches the slots from index 0 upward and takes the lowest free slot, or is dropped
// if none is free; a tick scans every slot, one memory read for each used slot that it checks;
// the slot scan is sequential, and the engine takes no new command until the current one is done
// reset: rst_n clears the queues, frees every slot and sets on_level to 4000; slot memories
// are not cleared and need no pass after reset
`timescale 1ns / 1ps
`default_nettype none

module timed_pulse_slot_table #(
    parameter int SLOTS = tpst_pkg::SLOTS_DEFAULT,
    parameter int PORTS = tpst_pkg::PORTS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        push,
    output logic             full,
    input  wire logic        operation,
    input  wire logic [3:0]  port,
    input  wire logic [15:0] duration_ms,
    input  wire logic [31:0] now_ms,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       out_port,
    output logic [11:0]      drive_level,
    output logic [1:0]       status,
    output logic             last
);

    localparam int CMD_W = $bits(tpst_pkg::cmd_t);
    localparam int RES_W = $bits(tpst_pkg::res_t);

    logic [11:0]      on_level_reg;
    logic             cfg_wr;

    logic             cmd_full;
    logic             cmd_push;
    tpst_pkg::cmd_t   cmd_wdata;
    logic [CMD_W-1:0] cmd_rbits;
    logic             cmd_empty;
    logic             cmd_pop;

    logic             res_full;
    logic             res_push;
    tpst_pkg::res_t   res_wdata;
    logic [RES_W-1:0] res_rbits;
    tpst_pkg::res_t   res_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == tpst_pkg::REG_ON_LEVEL);
    assign prdata = (paddr[2] == tpst_pkg::REG_ON_LEVEL) ? {20'd0, on_level_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_level_reg <= tpst_pkg::ON_LEVEL_RESET;
        end
        else if (cfg_wr)
        begin
            on_level_reg <= pwdata[11:0];
        end
    end

    tpst_front #(
        .PORTS(PORTS)
    ) u_front (
        .push       (push),
        .full       (full),
        .operation  (operation),
        .port       (port),
        .duration_ms(duration_ms),
        .now_ms     (now_ms),
        .cmd_full   (cmd_full),
        .cmd_push   (cmd_push),
        .cmd_data   (cmd_wdata)
    );

    tpst_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(2)
    ) u_cmd_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (cmd_push),
        .wdata(cmd_wdata),
        .full (cmd_full),
        .pop  (cmd_pop),
        .rdata(cmd_rbits),
        .empty(cmd_empty)
    );

    tpst_engine #(
        .SLOTS(SLOTS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_empty(cmd_empty),
        .cmd_data (tpst_pkg::cmd_t'(cmd_rbits)),
        .cmd_pop  (cmd_pop),
        .on_level (on_level_reg),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_wdata)
    );

    tpst_fifo #(
        .WIDTH(RES_W),
        .DEPTH(2)
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .wdata(res_wdata),
        .full (res_full),
        .pop  (pop),
        .rdata(res_rbits),
        .empty(empty)
    );

    assign res_head    = tpst_pkg::res_t'(res_rbits);
    assign out_port    = res_head.port;
    assign drive_level = res_head.level;
    assign status      = res_head.status;
    assign last        = res_head.last;

endmodule

`default_nettype wire

FILE: rtl/tpst_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tpst_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [11:0] drive_level,
    input wire logic [1:0]  status,
    input wire logic        last
);

    // a drop is a single zero-level word
    a_drop_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == tpst_pkg::ST_DROP) |-> (drive_level == '0 && last))
        else $error("dropped start word malformed");

    a_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == tpst_pkg::ST_ON) |-> last)
        else $error("turn-on word without last");

    a_off_level: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == tpst_pkg::ST_OFF) |-> (drive_level == '0))
        else $error("turn-off word with nonzero level");

    // turn-offs of one tick stay together until the last one
    a_tick_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last) |=> (empty || status == tpst_pkg::ST_OFF))
        else $error("tick results interleaved");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting word withdrawn");

endmodule

bind timed_pulse_slot_table tpst_checker u_tpst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .drive_level(drive_level),
    .status     (status),
    .last       (last)
);

`default_nettype wire
